[rtl/core/bpr_pkg.sv]
// bpr_pkg: shared constants, codes and controller/datapath command types
// for the bisection root finder; no dependencies
`default_nettype none

package bpr_pkg;

	localparam int END_W = 32;
	localparam int FX_W  = 48;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 48;

	localparam logic [CFG_INDEX_W-1:0] CFG_PRECISION = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT     = 1'b1;

	localparam logic [FX_W-1:0] PRECISION_RESET = 48'd268435;
	localparam int LIMIT_RESET = 100;

	localparam logic [1:0] SEL_LOW  = 2'd0;
	localparam logic [1:0] SEL_HIGH = 2'd1;
	localparam logic [1:0] SEL_MID  = 2'd2;

	typedef struct packed {
		logic       load;
		logic       eval_start;
		logic [1:0] eval_sel;
		logic       mul_mag;
		logic       mul_lo;
		logic       mul_hi;
		logic       mul_sum;
		logic       mul_sat;
		logic       keep_x2;
		logic       fin_a;
		logic       fin_b;
		logic       set_flo;
		logic       set_fhi;
		logic       bisect;
		logic       dec;
		logic       diff;
		logic       set_failed;
		logic       out_load;
	} bpr_cmd_t;

	typedef struct packed {
		logic too_wide;
		logic passes_zero;
		logic signs_differ;
		logic out_free;
	} bpr_status_t;

endpackage

`default_nettype wire

[rtl/core/bpr_in_if.sv]
// bpr_in_if: input channel carrying the two interval ends
// depends on bpr_pkg
`default_nettype none

interface bpr_in_if import bpr_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [END_W-1:0] left_end;
	logic signed [END_W-1:0] right_end;

	modport source(output valid, left_end, right_end, input ready);
	modport sink(input valid, left_end, right_end, output ready);
endinterface

`default_nettype wire

[rtl/core/bpr_out_if.sv]
// bpr_out_if: result channel carrying root, f(root), passes used and failure flag
// depends on bpr_pkg
`default_nettype none

interface bpr_out_if import bpr_pkg::*; #(
	parameter int COUNT_WIDTH = 10
);
	logic                    valid;
	logic                    ready;
	logic signed [END_W-1:0] root;
	logic signed [FX_W-1:0]  value_at_root;
	logic [COUNT_WIDTH-1:0]  passes_used;
	logic                    failed;

	modport source(output valid, root, value_at_root, passes_used, failed, input ready);
	modport sink(input valid, root, value_at_root, passes_used, failed, output ready);
endinterface

`default_nettype wire

[rtl/core/bpr_datapath.sv]
// bpr_datapath: interval registers, shared fixed-point multiplier, polynomial
// finish logic, config registers and output register; depends on bpr_pkg
`default_nettype none

module bpr_datapath import bpr_pkg::*; #(
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [END_W-1:0] in_left,
	input  logic signed [END_W-1:0] in_right,
	input  logic                    cfg_we,
	input  logic [CFG_INDEX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  bpr_cmd_t                cmd,
	output bpr_status_t             status,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic signed [END_W-1:0] out_root,
	output logic signed [FX_W-1:0]  out_value,
	output logic [COUNT_WIDTH-1:0]  out_used,
	output logic                    out_failed
);

	localparam logic signed [FX_W+1:0] TWO_FX = 50'(64'd2 << FRAC_BITS);
	localparam logic signed [FX_W+1:0] POS_MAX = 50'((64'd1 << (FX_W-1)) - 64'd1);
	localparam logic signed [FX_W+1:0] NEG_MIN = -POS_MAX - 50'sd1;

	function automatic logic signed [FX_W-1:0] sat50(input logic signed [FX_W+1:0] v);
		logic signed [FX_W-1:0] r;
		if (v > POS_MAX) begin
			r = POS_MAX[FX_W-1:0];
		end else if (v < NEG_MIN) begin
			r = NEG_MIN[FX_W-1:0];
		end else begin
			r = v[FX_W-1:0];
		end
		return r;
	endfunction

	logic [FX_W-1:0]          prec_q;
	logic [COUNT_WIDTH-1:0]   limit_q;
	logic signed [END_W-1:0]  lo_q, hi_q, x_q;
	logic signed [FX_W-1:0]   acc_q, x2_q, fx4_q, f_q, flo_q, fhi_q;
	logic signed [FX_W:0]     diff_q;
	logic [FX_W-1:0]          ma_q;
	logic [END_W-1:0]         mb_q;
	logic                     neg_q;
	logic [63:0]              prod_q, plo_q;
	logic [79:0]              sum_q;
	logic [COUNT_WIDTH-1:0]   passes_q;
	logic                     failed_q;
	logic                     out_valid_q;
	logic signed [END_W-1:0]  root_q;
	logic signed [FX_W-1:0]   value_q;
	logic [COUNT_WIDTH-1:0]   used_q;
	logic                     ofail_q;

	logic signed [END_W:0]    mid_sum;
	logic signed [END_W-1:0]  mid;
	logic signed [END_W-1:0]  x_sel;
	logic [END_W-1:0]         mul_a;
	logic [63:0]              mul_p;
	logic [79:0]              shifted;
	logic [FX_W-1:0]          lim;
	logic [FX_W-1:0]          qs;
	logic signed [FX_W-1:0]   mul_res;
	logic signed [FX_W:0]     neg_sum;
	logic                     too_wide;

	assign mid_sum = 33'(lo_q) + 33'(hi_q);
	assign mid     = mid_sum[END_W:1];

	always_comb begin
		unique case (cmd.eval_sel)
			SEL_LOW:  x_sel = lo_q;
			SEL_HIGH: x_sel = hi_q;
			default:  x_sel = mid;
		endcase
	end

	assign mul_a   = cmd.mul_hi ? {16'b0, ma_q[FX_W-1:END_W]} : ma_q[END_W-1:0];
	assign mul_p   = 64'(mul_a) * 64'(mb_q);
	assign shifted = sum_q >> FRAC_BITS;
	assign lim     = neg_q ? {1'b1, {(FX_W-1){1'b0}}} : {1'b0, {(FX_W-1){1'b1}}};
	assign qs      = (shifted > {32'b0, lim}) ? lim : shifted[FX_W-1:0];
	assign mul_res = neg_q ? -$signed(qs) : $signed(qs);

	assign neg_sum  = diff_q + $signed({1'b0, prec_q});
	assign too_wide = diff_q[FX_W] ? (neg_sum[FX_W] || (neg_sum == '0))
	                               : (diff_q[FX_W-1:0] >= prec_q);

	assign status.too_wide     = too_wide;
	assign status.passes_zero  = (passes_q == '0);
	assign status.signs_differ = flo_q[FX_W-1] ^ fhi_q[FX_W-1];
	assign status.out_free     = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q  <= PRECISION_RESET;
			limit_q <= COUNT_WIDTH'(LIMIT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRECISION: prec_q  <= cfg_data;
				CFG_LIMIT:     limit_q <= cfg_data[COUNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q     <= in_left;
			hi_q     <= in_right;
			passes_q <= limit_q;
		end
		if (cmd.eval_start) begin
			x_q   <= x_sel;
			acc_q <= 48'(x_sel);
		end
		if (cmd.mul_mag) begin
			ma_q  <= acc_q[FX_W-1] ? 48'(-acc_q) : 48'(acc_q);
			mb_q  <= x_q[END_W-1] ? 32'(-x_q) : 32'(x_q);
			neg_q <= acc_q[FX_W-1] ^ x_q[END_W-1];
		end
		if (cmd.mul_lo || cmd.mul_hi) begin
			prod_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			plo_q <= prod_q;
		end
		if (cmd.mul_sum) begin
			sum_q <= {prod_q[FX_W-1:0], 32'b0} + {16'b0, plo_q};
		end
		if (cmd.mul_sat) begin
			acc_q <= mul_res;
			if (cmd.keep_x2) begin
				x2_q <= mul_res;
			end
		end
		if (cmd.fin_a) begin
			fx4_q <= sat50({x2_q, 2'b00});
		end
		if (cmd.fin_b) begin
			f_q <= sat50(50'(acc_q) - 50'(fx4_q) + TWO_FX);
		end
		if (cmd.set_flo) begin
			flo_q <= f_q;
		end
		if (cmd.set_fhi) begin
			fhi_q <= f_q;
		end
		if (cmd.bisect) begin
			if (f_q[FX_W-1] == flo_q[FX_W-1]) begin
				lo_q  <= x_q;
				flo_q <= f_q;
			end else begin
				hi_q  <= x_q;
				fhi_q <= f_q;
			end
		end
		if (cmd.dec) begin
			passes_q <= passes_q - 1'b1;
		end
		if (cmd.diff) begin
			diff_q <= 49'(fhi_q) - 49'(flo_q);
		end
		if (cmd.set_failed) begin
			failed_q <= too_wide;
		end
		if (cmd.out_load) begin
			root_q  <= x_q;
			value_q <= f_q;
			used_q  <= limit_q - passes_q;
			ofail_q <= failed_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_root   = root_q;
	assign out_value  = value_q;
	assign out_used   = used_q;
	assign out_failed = ofail_q;

endmodule

`default_nettype wire

[rtl/core/bpr_ctrl.sv]
// bpr_ctrl: state machine sequencing polynomial evaluations and bisection
// passes; drives bpr_datapath through bpr_cmd_t, depends on bpr_pkg
`default_nettype none

module bpr_ctrl import bpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  bpr_status_t status,
	output bpr_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_START = 4'd1;
	localparam logic [3:0] S_MAG   = 4'd2;
	localparam logic [3:0] S_LO    = 4'd3;
	localparam logic [3:0] S_HI    = 4'd4;
	localparam logic [3:0] S_SUM   = 4'd5;
	localparam logic [3:0] S_SAT   = 4'd6;
	localparam logic [3:0] S_FIN1  = 4'd7;
	localparam logic [3:0] S_FIN2  = 4'd8;
	localparam logic [3:0] S_STORE = 4'd9;
	localparam logic [3:0] S_CHK   = 4'd10;
	localparam logic [3:0] S_TEST  = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	localparam logic [1:0] TGT_LOW  = 2'd0;
	localparam logic [1:0] TGT_HIGH = 2'd1;
	localparam logic [1:0] TGT_MID  = 2'd2;
	localparam logic [1:0] TGT_ROOT = 2'd3;

	logic [3:0] state_q, state_d;
	logic [1:0] tgt_q, tgt_d;
	logic [1:0] pow_q, pow_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		tgt_d   = tgt_q;
		pow_d   = pow_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					tgt_d    = TGT_LOW;
					state_d  = S_START;
				end
			end
			S_START: begin
				cmd.eval_start = 1'b1;
				cmd.eval_sel   = (tgt_q == TGT_LOW) ? SEL_LOW :
				                 (tgt_q == TGT_HIGH) ? SEL_HIGH : SEL_MID;
				pow_d          = 2'd0;
				state_d        = S_MAG;
			end
			S_MAG: begin
				cmd.mul_mag = 1'b1;
				state_d     = S_LO;
			end
			S_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_HI;
			end
			S_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_SUM;
			end
			S_SUM: begin
				cmd.mul_sum = 1'b1;
				state_d     = S_SAT;
			end
			S_SAT: begin
				cmd.mul_sat = 1'b1;
				cmd.keep_x2 = (pow_q == 2'd0);
				if (pow_q == 2'd3) begin
					state_d = S_FIN1;
				end else begin
					pow_d   = pow_q + 2'd1;
					state_d = S_MAG;
				end
			end
			S_FIN1: begin
				cmd.fin_a = 1'b1;
				state_d   = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin_b = 1'b1;
				state_d   = S_STORE;
			end
			S_STORE: begin
				unique case (tgt_q)
					TGT_LOW: begin
						cmd.set_flo = 1'b1;
						tgt_d       = TGT_HIGH;
						state_d     = S_START;
					end
					TGT_HIGH: begin
						cmd.set_fhi = 1'b1;
						state_d     = S_CHK;
					end
					TGT_MID: begin
						cmd.bisect = 1'b1;
						cmd.dec    = 1'b1;
						state_d    = S_CHK;
					end
					default: begin
						state_d = S_OUT;
					end
				endcase
			end
			S_CHK: begin
				cmd.diff = 1'b1;
				state_d  = S_TEST;
			end
			S_TEST: begin
				if (status.too_wide && !status.passes_zero) begin
					if (status.signs_differ) begin
						tgt_d   = TGT_MID;
						state_d = S_START;
					end else begin
						cmd.dec = 1'b1;
					end
				end else begin
					cmd.set_failed = 1'b1;
					tgt_d          = TGT_ROOT;
					state_d        = S_START;
				end
			end
			S_OUT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q   <= TGT_LOW;
			pow_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			tgt_q   <= tgt_d;
			pow_q   <= pow_d;
		end
	end

`ifndef SYNTHESIS
	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_START))
		else $error("load not followed by evaluation start");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !status.out_free) |=> (state_q == S_OUT))
		else $error("result dropped while output register busy");

	a_dec_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dec |-> !status.passes_zero)
		else $error("pass counter decremented at zero");

	a_fin_after_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN1) |-> ($past(state_q) == S_SAT && $past(pow_q) == 2'd3))
		else $error("polynomial finish before fifth power");
`endif

endmodule

`default_nettype wire

[rtl/core/bisection_polynomial_root.sv]
// bisection_polynomial_root: top level joining bpr_ctrl and bpr_datapath
// depends on bpr_pkg, bpr_in_if, bpr_out_if, bpr_ctrl, bpr_datapath
//
// Finds a root of f(x) = x^5 - 4x^2 + 2 on [left_end, right_end] by bisection.
// in_ch carries one interval per transaction (signed Q4.28 ends); out_ch returns
// the final midpoint, f at it (Q20.28, saturated), passes used and a failed flag.
// Config writes (cfg_we, cfg_index, cfg_data) set precision (index 0) and
// iteration_limit (index 1); write them only while no search is running.
// Each f evaluation runs four dependent products through the one shared
// 32x32 multiplier, each as magnitude, low half, high half, sum and saturate
// steps, then the finishing adds. A bisecting pass evaluates f once at the
// midpoint; a pass whose ends have the same sign only uses up a pass. The
// reset limit is 100 passes. One interval is searched at a time.
// in_ch.ready is high only while the search engine is idle; a finished result
// sits in the output register, so the next transaction is accepted while it
// waits. If the receiver still holds the previous result when the next one is
// done, the engine waits until out_ch is free.
// Reset clears the controller and output valid and restores the registers to
// precision 268435 and iteration_limit 100; no memory needs clearing.
`default_nettype none

module bisection_polynomial_root import bpr_pkg::*; #(
	parameter int FRAC_BITS   = 28,
	parameter int COUNT_WIDTH = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	bpr_in_if.sink                 in_ch,
	bpr_out_if.source              out_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	bpr_cmd_t    cmd;
	bpr_status_t status;
	logic        in_ready;

	assign in_ch.ready = in_ready;

	bpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	bpr_datapath #(
		.FRAC_BITS   (FRAC_BITS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_left    (in_ch.left_end),
		.in_right   (in_ch.right_end),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_root   (out_ch.root),
		.out_value  (out_ch.value_at_root),
		.out_used   (out_ch.passes_used),
		.out_failed (out_ch.failed)
	);

endmodule

`default_nettype wire

[dv/testbench.sv]
// testbench: directed table and random intervals for the bisection root finder,
// each result checked against a typed expectation or an in-bench bisection predictor
// depends on bpr_pkg, bpr_in_if, bpr_out_if and bisection_polynomial_root
`default_nettype none

module testbench;
	import bpr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 28;
	localparam longint ONE_Q = 64'sd268435456;

	localparam logic signed [31:0] END_MIN   = 32'sh8000_0000;
	localparam logic signed [31:0] END_MAX   = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] ONE_END   = 32'sh1000_0000;
	localparam logic signed [31:0] M_ONE_END = 32'shF000_0000;
	localparam logic signed [31:0] M_SEVEN   = 32'sh9000_0000;
	localparam logic signed [31:0] TWO_END   = 32'sh2000_0000;
	localparam logic signed [31:0] THREE_END = 32'sh3000_0000;
	localparam logic signed [31:0] HALF_END  = 32'sh0800_0000;
	localparam logic signed [31:0] ONE_HALF  = 32'sh1800_0000;

	localparam logic signed [47:0] F_TWO     = 48'sd536870912;
	localparam logic signed [47:0] F_M_ONE   = -48'sd268435456;
	localparam logic [47:0]        PREC_MAX  = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [31:0] root;
		logic signed [47:0] value;
		logic [9:0]         passes;
		logic               failed;
	} root_result_t;

	typedef struct packed {
		logic [47:0]        prec;
		logic [9:0]         limit;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic               typed;
		root_result_t       want;
	} interval_case_t;

	localparam root_result_t NO_RESULT = '0;

	localparam interval_case_t DIRECTED [17] = '{
		'{PRECISION_RESET, 10'd100, 32'sd0, 32'sd0, 1'b1, '{32'sd0, F_TWO, 10'd0, 1'b0}},
		'{PRECISION_RESET, 10'd100, ONE_END, ONE_END, 1'b1,
			'{ONE_END, F_M_ONE, 10'd0, 1'b0}},
		'{PRECISION_RESET, 10'd100, END_MIN, END_MAX, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd100, END_MAX, END_MIN, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd100, M_ONE_END, 32'sd0, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd100, 32'sd0, ONE_END, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd100, ONE_END, TWO_END, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd100, END_MIN, M_SEVEN, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd100, TWO_END, THREE_END, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd100, HALF_END, ONE_HALF, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd1, M_ONE_END, 32'sd0, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd0, END_MIN, END_MAX, 1'b1, '{-32'sd1, F_TWO, 10'd0, 1'b1}},
		'{48'd0, 10'd5, 32'sd0, 32'sd0, 1'b1, '{32'sd0, F_TWO, 10'd5, 1'b1}},
		'{PREC_MAX, 10'd100, END_MIN, END_MAX, 1'b1, '{-32'sd1, F_TWO, 10'd0, 1'b0}},
		'{48'd1, 10'd3, 32'sd1, -32'sd1, 1'b0, NO_RESULT},
		'{48'd0, 10'd1023, 32'sd0, ONE_END, 1'b0, NO_RESULT},
		'{PRECISION_RESET, 10'd1023, M_ONE_END, TWO_END, 1'b0, NO_RESULT}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bpr_in_if in_ch();
	bpr_out_if #(.COUNT_WIDTH(10)) out_ch();

	bisection_polynomial_root #(
		.FRAC_BITS(FRAC),
		.COUNT_WIDTH(10)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	root_result_t pending_roots[$];
	logic [47:0] precision_q = PRECISION_RESET;
	logic [9:0] pass_limit = 10'(LIMIT_RESET);
	int sender_idle = 0;
	int receiver_idle = 0;
	int mismatches = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sat48(input longint v);
		if (v > 64'sh7FFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF;
		if (v < -64'sh8000_0000_0000)
			return -64'sh8000_0000_0000;
		return v;
	endfunction

	// magnitude product, truncated toward zero, saturated to 48 bits
	function automatic longint fx_product(input longint a, input longint b);
		logic neg;
		longint unsigned ma, mb, lim;
		logic [127:0] p;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? longint'(-a) : a;
		mb = (b < 0) ? longint'(-b) : b;
		lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
		p = {64'd0, ma} * {64'd0, mb};
		p = p >> FRAC;
		if (p > {64'd0, lim})
			p = {64'd0, lim};
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint poly_at(input longint x);
		longint x2, x3, x4, x5;
		x2 = fx_product(x, x);
		x3 = fx_product(x2, x);
		x4 = fx_product(x3, x);
		x5 = fx_product(x4, x);
		return sat48(x5 - sat48(x2 * 4) + (longint'(2) <<< FRAC));
	endfunction

	function automatic logic span_too_wide(input longint f_a, input longint f_b);
		longint d;
		d = f_b - f_a;
		if (d < 0)
			d = -d;
		return longint'(d) >= longint'({16'd0, precision_q});
	endfunction

	function automatic root_result_t solve_bisection(input logic signed [31:0] a_in,
			input logic signed [31:0] b_in);
		longint lo, hi, f_lo, f_hi, mid, f_mid;
		int left;
		root_result_t r;
		lo = a_in;
		hi = b_in;
		f_lo = poly_at(lo);
		f_hi = poly_at(hi);
		left = pass_limit;
		while (span_too_wide(f_lo, f_hi) && left != 0) begin
			if ((f_lo < 0) != (f_hi < 0)) begin
				mid = (lo + hi) >>> 1;
				f_mid = poly_at(mid);
				if ((f_mid < 0) == (f_lo < 0)) begin
					lo = mid;
					f_lo = f_mid;
				end else begin
					hi = mid;
					f_hi = f_mid;
				end
			end
			left--;
		end
		r.failed = span_too_wide(f_lo, f_hi);
		mid = (lo + hi) >>> 1;
		f_mid = poly_at(mid);
		r.root = mid[31:0];
		r.value = f_mid[47:0];
		r.passes = 10'(int'(pass_limit) - left);
		return r;
	endfunction

	function automatic logic signed [31:0] pick_between(input longint lo, input longint hi);
		longint v;
		v = lo + longint'($urandom_range(0, 32'(hi - lo)));
		return v[31:0];
	endfunction

	task automatic flag_error(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_interval(input logic signed [31:0] a, input logic signed [31:0] b,
			input logic typed, input root_result_t want);
		while ($urandom_range(0, 99) < sender_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.left_end <= a;
		in_ch.right_end <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		pending_roots.push_back(typed ? want : solve_bisection(a, b));
	endtask

	task automatic apply_config(input logic [47:0] prec, input logic [9:0] limit);
		in_ch.valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PRECISION;
		cfg_data <= prec;
		@(posedge clk);
		cfg_index <= CFG_LIMIT;
		cfg_data <= {38'd0, limit};
		@(posedge clk);
		cfg_we <= 1'b0;
		precision_q = prec;
		pass_limit = limit;
	endtask

	// result side: check each transaction, then stall at random
	initial begin
		root_result_t want;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				if (pending_roots.size() == 0) begin
					flag_error("result with no interval pending");
				end else begin
					want = pending_roots.pop_front();
					if (out_ch.root !== want.root)
						flag_error($sformatf("root %0d, want %0d", out_ch.root, want.root));
					if (out_ch.value_at_root !== want.value)
						flag_error($sformatf("f(root) %0d, want %0d",
							out_ch.value_at_root, want.value));
					if (out_ch.passes_used !== want.passes)
						flag_error($sformatf("passes %0d, want %0d",
							out_ch.passes_used, want.passes));
					if (out_ch.failed !== want.failed)
						flag_error($sformatf("failed %0b, want %0b",
							out_ch.failed, want.failed));
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle);
		end
	end

	initial begin
		logic signed [31:0] a, b, t;
		logic [47:0] prec;
		logic [9:0] limit;
		int kind, count;
		in_ch.valid <= 1'b0;
		in_ch.left_end <= '0;
		in_ch.right_end <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PRECISION;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle = 24;
		receiver_idle = 65;
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].prec != precision_q || DIRECTED[i].limit != pass_limit)
				apply_config(DIRECTED[i].prec, DIRECTED[i].limit);
			send_interval(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int ph = 0; ph < 9; ph++) begin
			case (ph / 3)
				0: begin
					sender_idle = 24;
					receiver_idle = 65;
				end
				1: begin
					sender_idle = 65;
					receiver_idle = 24;
				end
				default: begin
					sender_idle = 0;
					receiver_idle = 0;
				end
			endcase
			case ($urandom_range(0, 3))
				0: prec = 48'($urandom_range(0, 1 << 20));
				1: prec = PRECISION_RESET;
				2: prec = 48'({$urandom, $urandom} >> 16);
				default: prec = 48'($urandom_range(1 << 20, 1 << 30));
			endcase
			limit = (ph == 8) ? 10'd1023 : 10'($urandom_range(0, 48));
			apply_config(prec, limit);
			count = (ph == 8) ? 4 : 37;
			repeat (count) begin
				kind = $urandom_range(0, 9);
				// well-formed brackets around each of the three roots, or random ends
				if (kind < 3) begin
					a = pick_between(-8 * ONE_Q, -ONE_Q);
					b = pick_between(-ONE_Q / 2, ONE_Q / 2);
				end else if (kind < 6) begin
					a = pick_between(-ONE_Q / 2, ONE_Q / 2);
					b = pick_between(ONE_Q * 9 / 10, ONE_Q * 11 / 10);
				end else if (kind < 9) begin
					a = pick_between(ONE_Q * 9 / 10, ONE_Q * 11 / 10);
					b = pick_between(ONE_Q * 18 / 10, 8 * ONE_Q - 1);
				end else begin
					a = $urandom;
					b = $urandom;
				end
				if ($urandom_range(0, 7) == 0) begin
					t = a;
					a = b;
					b = t;
				end
				send_interval(a, b, 1'b0, NO_RESULT);
			end
		end

		in_ch.valid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
